// ===== src/pcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_pkg
// shared widths, constants and types for the pixel color grading pipeline
// ----------------------------------------------------------------------------
package pcg_pkg;

  // gain format: unsigned, GAIN_FRAC_BITS fractional bits
  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_W         = 16;
  localparam int CFG_DATA_W     = 48;
  localparam int CFG_IDX_W      = 3;

  // register stages, input to output register
  localparam int NUM_STAGES   = 8;
  localparam int FRONT_STAGES = 5;
  localparam int TONE_STAGES  = 2;

  // contrast product: 10-bit signed channel offset times 17-bit signed gain
  localparam int CP_W = 27;
  // channel value after contrast, Q.8
  localparam int V_W  = CP_W - (GAIN_FRAC_BITS - 7);
  // luma products and their sum
  localparam int P_W  = V_W + 17;
  // channel minus grey
  localparam int D_W  = V_W + 1;
  // saturation product
  localparam int SP_W = D_W + 17;
  // saturated channel, Q.8
  localparam int S_W  = V_W + 18 - GAIN_FRAC_BITS;
  // tint product, Q(8+G)
  localparam int T_W  = S_W + 17;
  // shift that brings a tint product back to an integer byte
  localparam int TINT_SHIFT = 8 + GAIN_FRAC_BITS;

  // luma weights, Q16, red green blue
  localparam logic [15:0] LUMA_W [3] = '{16'd19595, 16'd38470, 16'd7471};
  localparam int LUMA_SHIFT = 16;

  // tone thresholds on integer luma in Q16
  localparam int TONE_L_W = 24;
  localparam logic [TONE_L_W-1:0] TONE_LOW_LIMIT  = 24'd5514855;
  localparam logic [TONE_L_W-1:0] TONE_HIGH_LIMIT = 24'd11029709;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);

  typedef logic signed [V_W-1:0]  vval_t;
  typedef logic signed [S_W-1:0]  sval_t;

  typedef struct packed {
    logic [GAIN_W-1:0] blue;
    logic [GAIN_W-1:0] green;
    logic [GAIN_W-1:0] red;
  } tint_t;

  typedef struct packed {
    logic [GAIN_W-1:0] contrast;
    logic [GAIN_W-1:0] saturation;
    tint_t             shadow;
    tint_t             midtone;
    tint_t             highlight;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST   = 3'd0,
    REG_SATURATION = 3'd1,
    REG_SHADOW     = 3'd2,
    REG_MIDTONE    = 3'd3,
    REG_HIGHLIGHT  = 3'd4
  } cfg_reg_e;

endpackage : pcg_pkg
`default_nettype wire

// ===== src/pcg_config.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_config
// grading gain registers behind the plain write port
// ----------------------------------------------------------------------------
module pcg_config import pcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam tint_t TINT_RESET = '{blue: GAIN_ONE, green: GAIN_ONE, red: GAIN_ONE};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast   <= GAIN_ONE;
      cfg.saturation <= GAIN_ONE;
      cfg.shadow     <= TINT_RESET;
      cfg.midtone    <= TINT_RESET;
      cfg.highlight  <= TINT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CONTRAST:   cfg.contrast   <= cfg_data[GAIN_W-1:0];
        REG_SATURATION: cfg.saturation <= cfg_data[GAIN_W-1:0];
        REG_SHADOW:     cfg.shadow     <= tint_t'(cfg_data);
        REG_MIDTONE:    cfg.midtone    <= tint_t'(cfg_data);
        REG_HIGHLIGHT:  cfg.highlight  <= tint_t'(cfg_data);
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule : pcg_config
`default_nettype wire

// ===== src/pcg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_front
// contrast, grey level and saturation over five register stages
// ----------------------------------------------------------------------------
module pcg_front import pcg_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] adv,
  input  logic [7:0]              pix [3],
  input  logic [GAIN_W-1:0]       contrast_gain,
  input  logic [GAIN_W-1:0]       saturation_gain,
  output sval_t                   sat [3]
);

  localparam logic signed [CP_W-1:0] CONTRAST_BIAS = CP_W'(255 << GAIN_FRAC_BITS);

  logic signed [16:0]     cg_s;
  logic signed [16:0]     sg_s;
  logic signed [9:0]      offs [3];
  logic signed [CP_W-1:0] csum [3];
  vval_t                  v_next [3];
  logic signed [P_W-1:0]  lp_next [3];
  logic signed [P_W-1:0]  lsum;
  vval_t                  grey_next;
  logic signed [D_W-1:0]  diff [3];
  logic signed [SP_W-1:0] sp_next [3];
  sval_t                  sat_next [3];

  // stage registers
  vval_t                  v1 [3];
  logic signed [P_W-1:0]  lp2 [3];
  vval_t                  v2 [3];
  vval_t                  v3 [3];
  vval_t                  grey3;
  logic signed [SP_W-1:0] sp4 [3];
  vval_t                  grey4;

  assign cg_s = $signed({1'b0, contrast_gain});
  assign sg_s = $signed({1'b0, saturation_gain});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // 2c - 255, contrast about mid-grey
      offs[i]    = $signed({1'b0, pix[i], 1'b0}) - 10'sd255;
      csum[i]    = CP_W'(offs[i]) * CP_W'(cg_s) + CONTRAST_BIAS;
      v_next[i]  = V_W'(csum[i] >>> (GAIN_FRAC_BITS - 7));
      lp_next[i] = P_W'(v1[i]) * P_W'($signed({1'b0, LUMA_W[i]}));
    end
    lsum      = lp2[0] + lp2[1] + lp2[2];
    grey_next = V_W'(lsum >>> LUMA_SHIFT);
    for (int i = 0; i < 3; i++) begin
      diff[i]     = D_W'(v3[i]) - D_W'(grey3);
      sp_next[i]  = SP_W'(diff[i]) * SP_W'(sg_s);
      sat_next[i] = S_W'(grey4) + S_W'(sp4[i] >>> GAIN_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) v1 <= v_next;
    if (adv[1]) begin
      lp2 <= lp_next;
      v2  <= v1;
    end
    if (adv[2]) begin
      v3    <= v2;
      grey3 <= grey_next;
    end
    if (adv[3]) begin
      sp4   <= sp_next;
      grey4 <= grey3;
    end
    if (adv[4]) sat <= sat_next;
  end

endmodule : pcg_front
`default_nettype wire

// ===== src/pcg_tone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg_tone
// tone luma, tint selection, tint gain and final clamp
// ----------------------------------------------------------------------------
module pcg_tone import pcg_pkg::*; (
  input  logic                   clk,
  input  logic [TONE_STAGES-1:0] adv,
  input  sval_t                  sat [3],
  input  tint_t                  shadow_tint,
  input  tint_t                  midtone_tint,
  input  tint_t                  highlight_tint,
  output logic [7:0]             graded [3]
);

  logic [7:0]            k [3];
  logic [TONE_L_W-1:0]   luma;
  tint_t                 tint_next;
  logic [GAIN_W-1:0]     gain [3];
  logic signed [T_W-1:0] t_next [3];

  tint_t                 tint6;
  sval_t                 sat6 [3];
  logic signed [T_W-1:0] t7 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // clamped integer copy for tone measurement
      if (sat[i][S_W-1])
        k[i] = 8'd0;
      else if (|sat[i][S_W-2:16])
        k[i] = 8'hff;
      else
        k[i] = sat[i][15:8];
    end
    luma = TONE_L_W'(LUMA_W[0]) * TONE_L_W'(k[0])
         + TONE_L_W'(LUMA_W[1]) * TONE_L_W'(k[1])
         + TONE_L_W'(LUMA_W[2]) * TONE_L_W'(k[2]);
    priority if (luma < TONE_LOW_LIMIT)
      tint_next = shadow_tint;
    else if (luma < TONE_HIGH_LIMIT)
      tint_next = midtone_tint;
    else
      tint_next = highlight_tint;

    gain[0] = tint6.red;
    gain[1] = tint6.green;
    gain[2] = tint6.blue;
    for (int i = 0; i < 3; i++) begin
      t_next[i] = T_W'(sat6[i]) * T_W'($signed({1'b0, gain[i]}));
      if (t7[i][T_W-1])
        graded[i] = 8'd0;
      else if (|t7[i][T_W-2:TINT_SHIFT+8])
        graded[i] = 8'hff;
      else
        graded[i] = t7[i][TINT_SHIFT+7:TINT_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tint6 <= tint_next;
      sat6  <= sat;
    end
    if (adv[1]) t7 <= t_next;
  end

endmodule : pcg_tone
`default_nettype wire

// ===== src/pixel_color_grading_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_color_grading_unit
// contrast, saturation and tone tint grading of one rgba8 pixel per item
// an accepted item passes all eight register stages on its way to out_valid
// throughput: one item per cycle while out_stall is low, through the eight-stage pipeline
// a stall only holds stages that carry an item; bubbles ahead of it fill up
// reset clears all stage valid bits and loads every gain with 1.0
// ----------------------------------------------------------------------------
module pixel_color_grading_unit import pcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input item channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  // output item channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // raw pixel and bypass flag riding alongside the arithmetic
  typedef struct packed {
    logic       pass;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

  cfg_t                  cfg;
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   ready;
  logic [NUM_STAGES-1:0] adv;
  side_t                 side [NUM_STAGES-1];
  side_t                 side_in;
  logic [7:0]            pix [3];
  sval_t                 sat [3];
  logic [7:0]            graded [3];

  pcg_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage advance: a stage loads when it is empty or the next one moves on
  always_comb begin
    ready[NUM_STAGES] = !out_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
    adv = ready[NUM_STAGES-1:0];
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) valid[i] <= valid[i-1];
      end
    end
  end

  // transparent pixels take the bypass path at the output register
  assign side_in = '{pass: (in_alpha == 8'd0), alpha: in_alpha,
                     red: in_red, green: in_green, blue: in_blue};

  always_ff @(posedge clk) begin
    if (adv[0]) side[0] <= side_in;
    for (int i = 1; i < NUM_STAGES - 1; i++) begin
      if (adv[i]) side[i] <= side[i-1];
    end
  end

  assign pix[0] = in_red;
  assign pix[1] = in_green;
  assign pix[2] = in_blue;

  // stages 0..4: contrast, luma products, grey, saturation product, saturation
  pcg_front u_front (
    .clk             (clk),
    .adv             (adv[FRONT_STAGES-1:0]),
    .pix             (pix),
    .contrast_gain   (cfg.contrast),
    .saturation_gain (cfg.saturation),
    .sat             (sat)
  );

  // stages 5..6: tint choice, tint product
  pcg_tone u_tone (
    .clk            (clk),
    .adv            (adv[FRONT_STAGES+TONE_STAGES-1:FRONT_STAGES]),
    .sat            (sat),
    .shadow_tint    (cfg.shadow),
    .midtone_tint   (cfg.midtone),
    .highlight_tint (cfg.highlight),
    .graded         (graded)
  );

  // stage 7: output register with bypass select
  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES-1]) begin
      out_alpha <= side[NUM_STAGES-2].alpha;
      if (side[NUM_STAGES-2].pass) begin
        out_red   <= side[NUM_STAGES-2].red;
        out_green <= side[NUM_STAGES-2].green;
        out_blue  <= side[NUM_STAGES-2].blue;
      end else begin
        out_red   <= graded[0];
        out_green <= graded[1];
        out_blue  <= graded[2];
      end
    end
  end

endmodule : pixel_color_grading_unit
`default_nettype wire

// ===== verif/pcg_grade_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_grade_checker
// watches the pixel, result and register-write ports of the grading unit,
// keeps its own register copy, grades every accepted pixel and compares
// ----------------------------------------------------------------------------
module pcg_grade_checker import pcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  input  logic [7:0]            out_alpha,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam longint WEIGHT_R = 19595;
  localparam longint WEIGHT_G = 38470;
  localparam longint WEIGHT_B = 7471;

  cfg_t   grading_regs;
  pixel_t graded_pending[$];

  initial errors = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic longint to_byte(input longint q8);
    if (q8 < 0) return 0;
    return ((q8 >>> 8) > 255) ? 255 : (q8 >>> 8);
  endfunction

  function automatic logic [7:0] tinted(input longint s, input logic [GAIN_W-1:0] g);
    longint t;
    t = s * longint'(g);
    if (t < 0) return 8'd0;
    t = t >>> (8 + GAIN_FRAC_BITS);
    return (t > 255) ? 8'd255 : 8'(t);
  endfunction

  function automatic pixel_t grade_pixel(input pixel_t px, input cfg_t regs);
    longint chan[3];
    longint v[3];
    longint s[3];
    longint k[3];
    longint grey, luma;
    tint_t  tone;
    pixel_t res;
    res = px;
    if (px.alpha == 8'd0) return res;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    // contrast about mid-grey, Q.8
    for (int i = 0; i < 3; i++)
      v[i] = ((2 * chan[i] - 255) * longint'(regs.contrast)
              + (longint'(255) << GAIN_FRAC_BITS)) >>> (GAIN_FRAC_BITS - 7);
    grey = (WEIGHT_R * v[0] + WEIGHT_G * v[1] + WEIGHT_B * v[2]) >>> 16;
    for (int i = 0; i < 3; i++) begin
      s[i] = grey + (((v[i] - grey) * longint'(regs.saturation)) >>> GAIN_FRAC_BITS);
      k[i] = to_byte(s[i]);
    end
    // tone band from the clamped integer copy
    luma = WEIGHT_R * k[0] + WEIGHT_G * k[1] + WEIGHT_B * k[2];
    if (luma < longint'(TONE_LOW_LIMIT))
      tone = regs.shadow;
    else if (luma < longint'(TONE_HIGH_LIMIT))
      tone = regs.midtone;
    else
      tone = regs.highlight;
    res.red   = tinted(s[0], tone.red);
    res.green = tinted(s[1], tone.green);
    res.blue  = tinted(s[2], tone.blue);
    return res;
  endfunction

  // register copy, low bits of the write data only for contrast and saturation
  always @(posedge clk) begin
    if (rst) begin
      grading_regs.contrast   <= GAIN_ONE;
      grading_regs.saturation <= GAIN_ONE;
      grading_regs.shadow     <= {3{GAIN_ONE}};
      grading_regs.midtone    <= {3{GAIN_ONE}};
      grading_regs.highlight  <= {3{GAIN_ONE}};
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONTRAST:   grading_regs.contrast   <= cfg_data[GAIN_W-1:0];
        REG_SATURATION: grading_regs.saturation <= cfg_data[GAIN_W-1:0];
        REG_SHADOW:     grading_regs.shadow     <= cfg_data;
        REG_MIDTONE:    grading_regs.midtone    <= cfg_data;
        REG_HIGHLIGHT:  grading_regs.highlight  <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      graded_pending.delete();
    end else begin
      if (in_valid && !in_stall)
        graded_pending.push_back(grade_pixel({in_red, in_green, in_blue, in_alpha},
                                             grading_regs));
      if (out_valid && !out_stall) begin
        if (graded_pending.size() == 0) begin
          report_mismatch($sformatf("item %0d/%0d/%0d/%0d with no pixel pending",
                                    out_red, out_green, out_blue, out_alpha));
        end else begin
          want = graded_pending.pop_front();
          if (out_red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", out_red, want.red));
          if (out_green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", out_green, want.green));
          if (out_blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", out_blue, want.blue));
          if (out_alpha !== want.alpha)
            report_mismatch($sformatf("alpha got %0d want %0d", out_alpha, want.alpha));
        end
      end
    end
    pending <= graded_pending.size();
  end

endmodule

// ===== verif/pixel_color_grading_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_grading_unit_test
// drives pixels and register settings into the grading unit with random
// gaps on both channels; the checker grades each pixel and counts failures
// ----------------------------------------------------------------------------
module pixel_color_grading_unit_test;
  import pcg_pkg::*;

  // spare register indexes, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 200;
  // pipeline is eight deep, give it some slack
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_WAIT        = 12;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_red, in_green, in_blue, in_alpha;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_red, out_green, out_blue, out_alpha;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int cycle_count = 0;
  int pixels_sent = 0;
  int transparent_sent = 0;
  int settings_applied = 0;
  int stall_left = 0;
  int stall_draw = 0;
  // when set, that side runs with no gaps at all
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always #5 clk = ~clk;

  pixel_color_grading_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcg_grade_checker grade_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // safety net against a hung pipeline
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: after every accepted item draw a stall of random length
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw > 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // one pixel, with a drawn gap ahead of it; valid stays high afterwards
  task automatic send_pixel(input logic [7:0] r, g, b, a);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    if (a == 8'd0) transparent_sent++;
  endtask

  // drop valid and let every graded pixel come back before going on
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all five registers plus one spare index, upper data bits of the two gain writes scrambled
  task automatic program_grading(input cfg_t s);
    cfg_write <= 1'b1;
    cfg_index <= REG_CONTRAST;
    cfg_data  <= {$urandom(), s.contrast};
    @(posedge clk);
    cfg_index <= REG_SATURATION;
    cfg_data  <= {$urandom(), s.saturation};
    @(posedge clk);
    cfg_index <= REG_SHADOW;
    cfg_data  <= s.shadow;
    @(posedge clk);
    cfg_index <= REG_MIDTONE;
    cfg_data  <= s.midtone;
    @(posedge clk);
    cfg_index <= REG_HIGHLIGHT;
    cfg_data  <= s.highlight;
    @(posedge clk);
    cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
    cfg_data  <= CFG_DATA_W'({$urandom(), $urandom()});
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [GAIN_W-1:0] random_gain;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_ONE;
      2: return '1;
      3: return GAIN_W'($urandom_range(0, 2 * GAIN_ONE));
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  function automatic tint_t random_tint;
    tint_t t;
    t.red   = random_gain();
    t.green = random_gain();
    t.blue  = random_gain();
    return t;
  endfunction

  function automatic logic [7:0] random_channel;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  // distinct per-band tints so a wrong band choice shows up
  function automatic cfg_t banded_setting;
    cfg_t s;
    s.contrast   = GAIN_ONE;
    s.saturation = GAIN_ONE;
    s.shadow     = '{blue: GAIN_ONE << 1, green: GAIN_ONE, red: GAIN_ONE >> 1};
    s.midtone    = '{blue: GAIN_ONE >> 2, green: GAIN_ONE << 1, red: GAIN_ONE};
    s.highlight  = '{blue: GAIN_ONE, green: GAIN_ONE >> 1, red: GAIN_ONE << 2};
    return s;
  endfunction

  function automatic cfg_t flat_setting(input logic [GAIN_W-1:0] g);
    cfg_t s;
    s.contrast   = g;
    s.saturation = g;
    s.shadow     = {3{g}};
    s.midtone    = {3{g}};
    s.highlight  = {3{g}};
    return s;
  endfunction

  function automatic cfg_t random_setting;
    cfg_t s;
    s.contrast   = random_gain();
    s.saturation = random_gain();
    s.shadow     = random_tint();
    s.midtone    = random_tint();
    s.highlight  = random_tint();
    return s;
  endfunction

  initial begin
    cfg_t setting;
    logic [7:0] a;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    in_alpha  = '0;
    cfg_write = 1'b0;
    cfg_index = REG_CONTRAST;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, gains at reset value: corners and transparent passthrough
    send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0,   8'd1);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd128);
    send_pixel(8'd0,   8'd0,   8'd255, 8'd255);
    send_pixel(8'd12,  8'd200, 8'd77,  8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    drain_pipeline();

    // greys either side of both tone thresholds
    program_grading(banded_setting());
    send_pixel(8'd84,  8'd84,  8'd84,  8'd255);
    send_pixel(8'd85,  8'd85,  8'd85,  8'd255);
    send_pixel(8'd168, 8'd168, 8'd168, 8'd255);
    send_pixel(8'd169, 8'd169, 8'd169, 8'd255);
    send_pixel(8'd127, 8'd128, 8'd127, 8'd64);
    drain_pipeline();

    // full-scale gains push intermediates far out of range
    program_grading(flat_setting('1));
    send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd128, 8'd7);
    send_pixel(8'd128, 8'd127, 8'd0,   8'd200);
    drain_pipeline();

    // zero gains collapse everything to grey then to black
    program_grading(flat_setting('0));
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd40,  8'd90,  8'd200, 8'd3);
    send_pixel(8'd0,   8'd255, 8'd0,   8'd0);
    drain_pipeline();

    // random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: setting = banded_setting();
        1: setting = flat_setting('1);
        2: setting = flat_setting('0);
        3: setting = flat_setting(GAIN_ONE);
        default: setting = random_setting();
      endcase
      program_grading(setting);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // new pacing every 50 pixels, sometimes a side runs gapless
        if (n % 50 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        // sender holds off mid-phase until the pipeline is empty
        if (n == ITEMS_PER_PHASE / 2)
          drain_pipeline();
        case ($urandom_range(0, 7))
          0: a = 8'd0;
          1: a = 8'd255;
          default: a = 8'($urandom_range(1, 255));
        endcase
        send_pixel(random_channel(), random_channel(), random_channel(), a);
      end
      drain_pipeline();
    end

    $display("graded %0d pixels (%0d transparent) under %0d register settings",
             pixels_sent, transparent_sent, settings_applied + 1);
    $display("settings spanned zero, unity, full-scale and random gains, spare writes");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pcg_pkg.sv
src/pcg_config.sv
src/pcg_front.sv
src/pcg_tone.sv
src/pixel_color_grading_unit.sv
verif/pcg_grade_checker.sv
verif/pixel_color_grading_unit_test.sv
